### src/log2h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the log2 latency histogram.
// No dependencies.
package log2h_pkg;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_READ   = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_UPDATE
  } state_e;

  // packed so that min lands in the low bits
  typedef struct packed {
    logic [63:0] count;
    logic [63:0] total;
    logic [63:0] max;
    logic [63:0] min;
  } stats_t;

  typedef struct packed {
    logic clear;
    logic update;
  } memctl_t;

  localparam stats_t STATS_EMPTY = '{count: '0, total: '0, max: '0, min: '1};

endpackage
`default_nettype wire

### src/log2h_slot_map.sv
`timescale 1ns / 1ps
`default_nettype none
// Type tag to slot lookup and allocation of pool slots.
// Depends on nothing beyond the clock and reset.
module log2h_slot_map #(
  parameter int POOL_SLOTS = 5,
  parameter int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1,
  parameter int UW = $clog2(POOL_SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [6:0]    tag_i,
  input  logic          alloc_i,
  output logic          hit_o,
  output logic [SW-1:0] hit_slot_o,
  output logic [UW-1:0] used_o,
  output logic          full_o
);

  logic [6:0]    tag_q [POOL_SLOTS];
  logic [UW-1:0] used_q;

  always_comb begin
    hit_o      = 1'b0;
    hit_slot_o = '0;
    for (int i = 0; i < POOL_SLOTS; i++) begin
      if (!hit_o && (UW'(i) < used_q) && (tag_q[i] == tag_i)) begin
        hit_o      = 1'b1;
        hit_slot_o = SW'(i);
      end
    end
  end

  assign used_o = used_q;
  assign full_o = (used_q == UW'(POOL_SLOTS));

  always_ff @(posedge clk_i) begin
    if (alloc_i) begin
      tag_q[SW'(used_q)] <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (alloc_i) begin
      used_q <= used_q + UW'(1);
    end
  end

endmodule
`default_nettype wire

### src/log2h_bucket_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Bucket counter memory with saturating read-modify-write.
// Depends on log2h_pkg.
module log2h_bucket_mem #(
  parameter int DEPTH = 320,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  log2h_pkg::memctl_t ctl_i,
  input  logic [AW-1:0]     clr_addr_i,
  input  logic [AW-1:0]     addr_i,
  output logic [31:0]       rdata_o,
  output logic [31:0]       inc_o
);
  import log2h_pkg::*;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  assign rdata_o = rdata_q;
  assign inc_o   = (rdata_q == '1) ? rdata_q : rdata_q + 32'd1;

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      mem[clr_addr_i] <= '0;
    end else if (ctl_i.update) begin
      mem[addr_i] <= inc_o;
    end
    rdata_q <= mem[addr_i];
  end

endmodule
`default_nettype wire

### src/log2h_stats_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// Per-slot min, max, total and count memory with update logic.
// Depends on log2h_pkg.
module log2h_stats_mem #(
  parameter int POOL_SLOTS = 5,
  parameter int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
  input  logic               clk_i,
  input  log2h_pkg::memctl_t ctl_i,
  input  logic [SW-1:0]      clr_addr_i,
  input  logic [SW-1:0]      addr_i,
  input  logic [63:0]        sample_i,
  output log2h_pkg::stats_t  rdata_o,
  output log2h_pkg::stats_t  upd_o
);
  import log2h_pkg::*;

  stats_t mem [POOL_SLOTS];
  stats_t rdata_q;

  assign rdata_o = rdata_q;

  always_comb begin
    upd_o.min   = (sample_i < rdata_q.min) ? sample_i : rdata_q.min;
    upd_o.max   = (sample_i > rdata_q.max) ? sample_i : rdata_q.max;
    upd_o.total = rdata_q.total + sample_i;
    upd_o.count = rdata_q.count + 64'd1;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      mem[clr_addr_i] <= STATS_EMPTY;
    end else if (ctl_i.update) begin
      mem[addr_i] <= upd_o;
    end
    rdata_q <= mem[addr_i];
  end

endmodule
`default_nettype wire

### src/log2_latency_histogram.sv
`timescale 1ns / 1ps
`default_nettype none
// Log2 latency histogram, top level. Uses log2h_pkg, log2h_slot_map,
// log2h_bucket_mem and log2h_stats_mem.
// An accepted item passes through S_READ, then S_UPDATE, where its result is
// registered; s_axis_tready is low until then, and S_UPDATE waits while the output
// is held. The bucket and stats memories are read, then updated and written back.
// Reset: after rst_ni a clearing pass over all POOL_SLOTS*NUM_BUCKETS addresses
// zeroes the buckets, sets stats to STATS_EMPTY; s_axis_tready stays low meanwhile.
module log2_latency_histogram #(
  parameter int POOL_SLOTS  = 5,
  parameter int NUM_BUCKETS = 64,
  parameter int TYPE_CODES  = 127
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // type_code, sample_value, bucket_index, zero pad
  input  logic         s_axis_tuser,  // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [287:0] m_axis_tdata,  // bucket_count, min_value, max_value, total_sum,
                                      // sample_count
  output logic [1:0]   m_axis_tuser   // status
);
  import log2h_pkg::*;

  localparam int DEPTH = POOL_SLOTS * NUM_BUCKETS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int UW    = $clog2(POOL_SLOTS + 1);
  localparam int BW    = $clog2(NUM_BUCKETS);

  function automatic logic [5:0] log2_floor(logic [63:0] v);
    logic [5:0] b;
    b = '0;
    for (int i = 1; i < 64; i++) begin
      if (v[i]) b = 6'(i);
    end
    return b;
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] clr_q;

  logic [6:0]  in_tag;
  logic [63:0] in_val;
  logic [5:0]  in_bidx;
  logic        accept, in_rec, in_range, in_ok, alloc;
  logic        hit, full;
  logic [SW-1:0] hit_slot, in_slot;
  logic [UW-1:0] used;
  logic [5:0]    rec_b6;
  logic [BW-1:0] in_bkt;

  logic          rec_q, ok_q, bzero_q;
  logic [63:0]   val_q;
  logic [SW-1:0] slot_q;
  logic [AW-1:0] baddr_q;

  logic        out_free, wb;
  memctl_t     bctl, sctl;
  logic [31:0] b_rdata, b_inc;
  stats_t      s_rdata, s_upd;

  logic        m_valid_q;
  status_e     m_status_q;
  logic [31:0] m_bkt_q;
  stats_t      m_stats_q;

  assign in_tag  = s_axis_tdata[6:0];
  assign in_val  = s_axis_tdata[70:7];
  assign in_bidx = s_axis_tdata[76:71];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign in_rec   = (req_e'(s_axis_tuser) == REQ_RECORD);
  assign in_range = (9'(in_tag) < 9'(TYPE_CODES));
  assign in_ok    = in_range && (hit || (in_rec && !full));
  assign alloc    = accept && in_rec && in_range && !hit && !full;
  assign in_slot  = hit ? hit_slot : SW'(used);
  assign rec_b6   = log2_floor(in_val);

  always_comb begin
    if (in_rec) begin
      in_bkt = (8'(rec_b6) > 8'(NUM_BUCKETS - 1)) ? BW'(NUM_BUCKETS - 1) : BW'(rec_b6);
    end else begin
      in_bkt = BW'(in_bidx);
    end
  end

  log2h_slot_map #(.POOL_SLOTS(POOL_SLOTS)) u_slot_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (in_tag),
    .alloc_i    (alloc),
    .hit_o      (hit),
    .hit_slot_o (hit_slot),
    .used_o     (used),
    .full_o     (full)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rec_q   <= in_rec;
      ok_q    <= in_ok;
      bzero_q <= !in_rec && (8'(in_bidx) >= 8'(NUM_BUCKETS));
      val_q   <= in_val;
      slot_q  <= in_slot;
      baddr_q <= AW'(in_slot) * AW'(NUM_BUCKETS) + AW'(in_bkt);
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;
  assign wb       = (state_q == S_UPDATE) && out_free && rec_q && ok_q;

  assign bctl.clear  = (state_q == S_CLEAR);
  assign bctl.update = wb;
  assign sctl.clear  = (state_q == S_CLEAR) && (clr_q < AW'(POOL_SLOTS));
  assign sctl.update = wb;

  log2h_bucket_mem #(.DEPTH(DEPTH)) u_bucket_mem (
    .clk_i      (clk_i),
    .ctl_i      (bctl),
    .clr_addr_i (clr_q),
    .addr_i     (baddr_q),
    .rdata_o    (b_rdata),
    .inc_o      (b_inc)
  );

  log2h_stats_mem #(.POOL_SLOTS(POOL_SLOTS)) u_stats_mem (
    .clk_i      (clk_i),
    .ctl_i      (sctl),
    .clr_addr_i (SW'(clr_q)),
    .addr_i     (slot_q),
    .sample_i   (val_q),
    .rdata_o    (s_rdata),
    .upd_o      (s_upd)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE:   if (accept) state_d = S_READ;
      S_READ:   state_d = S_UPDATE;
      S_UPDATE: if (out_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if ((state_q == S_UPDATE) && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_UPDATE) && out_free) begin
      if (!ok_q) begin
        m_status_q <= rec_q ? ST_FULL : ST_ABSENT;
        m_bkt_q    <= '0;
        m_stats_q  <= STATS_EMPTY;
      end else if (rec_q) begin
        m_status_q <= ST_OK;
        m_bkt_q    <= b_inc;
        m_stats_q  <= s_upd;
      end else begin
        m_status_q <= ST_OK;
        m_bkt_q    <= bzero_q ? 32'd0 : b_rdata;
        m_stats_q  <= s_rdata;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_stats_q, m_bkt_q};
  assign m_axis_tuser  = m_status_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("item accepted while another is in flight");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= UW'(POOL_SLOTS))
    else $error("slot pool overrun");

  a_err_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_status_q != ST_OK)) |->
      (m_stats_q == STATS_EMPTY) && (m_bkt_q == 32'd0))
    else $error("error result carries statistics");

  a_wb_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb |=> m_valid_q && (m_status_q == ST_OK))
    else $error("write-back without a matching result");

endmodule
`default_nettype wire
